>>> rtl/cpfs_pkg.sv
// shared types, constants and saturation helper for the clamped polynomial force scaler
// no dependencies; imported by the interfaces, the core and the checker
package cpfs_pkg;

	localparam int DATA_W     = 32;
	localparam int FRAC_BITS  = 16;
	localparam int MAX_DEGREE = 3;
	localparam int NUM_COEF   = 4;
	localparam int DEG_W      = 2;
	localparam int CFG_IDX_W  = 3;

	// multiplier operands: a is 33 bit signed so the unsigned gain fits
	localparam int OPA_W  = DATA_W + 1;
	localparam int PROD_W = OPA_W + DATA_W;
	localparam int RSUM_W = PROD_W + 1;
	localparam int WIDE_W = RSUM_W - FRAC_BITS;

	localparam logic [DEG_W-1:0] DEG_CAP = (MAX_DEGREE < NUM_COEF - 1) ?
		DEG_W'(MAX_DEGREE) : DEG_W'(NUM_COEF - 1);

	localparam logic signed [RSUM_W-1:0] ROUND_HALF = RSUM_W'(1) <<< (FRAC_BITS - 1);

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_HIGH   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_POLY_DEGREE  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_0       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_1       = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_2       = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_3       = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_THERMAL_GAIN = 3'd7;

	// command and kind codes
	localparam logic CMD_LAMBDA = 1'b0;
	localparam logic CMD_FORCE  = 1'b1;

	// reset values
	localparam logic signed [DATA_W-1:0] RANGE_LOW_RST  = {1'b1, {(DATA_W-1){1'b0}}};
	localparam logic signed [DATA_W-1:0] RANGE_HIGH_RST = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic [DATA_W-1:0]        GAIN_RST       = DATA_W'(39066);

	typedef logic signed [DATA_W-1:0] data_t;

	typedef struct packed {
		logic  flag;
		data_t value;
	} sat_res_t;

	localparam logic signed [WIDE_W-1:0] WIDE_MAX = WIDE_W'(RANGE_HIGH_RST);
	localparam logic signed [WIDE_W-1:0] WIDE_MIN = WIDE_W'(RANGE_LOW_RST);

	// clip a wide signed value to the 32 bit range
	function automatic sat_res_t sat_wide(input logic signed [WIDE_W-1:0] v);
		sat_res_t r;
		if (v > WIDE_MAX) begin
			r.flag  = 1'b1;
			r.value = RANGE_HIGH_RST;
		end else if (v < WIDE_MIN) begin
			r.flag  = 1'b1;
			r.value = RANGE_LOW_RST;
		end else begin
			r.flag  = 1'b0;
			r.value = v[DATA_W-1:0];
		end
		return r;
	endfunction

endpackage

>>> rtl/cpfs_if.sv
// valid/ready channel interfaces for sample and result transactions
// depends on cpfs_pkg
interface cpfs_in_if;
	import cpfs_pkg::*;

	logic  valid;
	logic  ready;
	logic  command;
	data_t sample_value;
	logic  last_component;

	modport source (output valid, output command, output sample_value,
		output last_component, input ready);
	modport sink (input valid, input command, input sample_value,
		input last_component, output ready);
endinterface

interface cpfs_out_if;
	import cpfs_pkg::*;

	logic  valid;
	logic  ready;
	logic  kind;
	data_t result_value;
	logic  saturated;
	logic  last_out;

	modport source (output valid, output kind, output result_value,
		output saturated, output last_out, input ready);
	modport sink (input valid, input kind, input result_value,
		input saturated, input last_out, output ready);
endinterface

>>> rtl/clamped_poly_force_scaler_core.sv
// clamped polynomial force scaler: horner evaluation on one shared multiplier
// depends on cpfs_pkg and the channel interfaces in cpfs_if.sv
//
//  channel  dir  payload                                         transaction when
//  sample   in   command, sample_value, last_component           valid && ready
//  result   out  kind, result_value, saturated, last_out         valid && ready
//  cfg      in   cfg_index, cfg_data                             cfg_we high
//
// force item: multiply, round and load output, then back to idle for the next item
// lambda item: clamp, d horner steps and a final gain pass, d the effective degree; each horner step is one
// pass of multiply, round and coefficient add through the single 33x32 multiplier
// reset clears control, sets the configuration registers to their reset values and clears the force factor
// a full output register with ready low holds the sequencer before it returns to idle
module clamped_poly_force_scaler_core (
	input  logic                       clk,
	input  logic                       arst_n,
	cpfs_in_if.sink                    sample,
	cpfs_out_if.source                 result,
	input  logic                       cfg_we,
	input  logic [cpfs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [cpfs_pkg::DATA_W-1:0]    cfg_data
);
	import cpfs_pkg::*;

	// sequencer states
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CLAMP = 3'd1;
	localparam logic [2:0] S_STEP  = 3'd2;
	localparam logic [2:0] S_MUL   = 3'd3;
	localparam logic [2:0] S_RND   = 3'd4;
	localparam logic [2:0] S_ADD   = 3'd5;
	localparam logic [2:0] S_DONE  = 3'd6;

	// configuration registers
	data_t             range_low_q;
	data_t             range_high_q;
	logic [DEG_W-1:0]  poly_degree_q;
	data_t             coef_q [NUM_COEF];
	logic [DATA_W-1:0] gain_q;

	// item state
	logic [2:0]        state_q;
	logic              cmd_q;
	logic              last_q;
	data_t             x_q;
	data_t             acc_q;
	data_t             factor_q;
	logic [DEG_W-1:0]  cnt_q;
	logic              final_q;
	logic              sat_q;

	// shared multiplier
	logic signed [OPA_W-1:0]  op_a_q;
	data_t                    op_b_q;
	logic signed [PROD_W-1:0] prod_q;

	// output register
	logic  out_valid_q;
	logic  out_kind_q;
	data_t out_value_q;
	logic  out_sat_q;
	logic  out_last_q;

	logic                     accept;
	logic [DEG_W-1:0]         deg_eff;
	logic [DEG_W-1:0]         coef_sel;
	data_t                    coef_rd;
	data_t                    x_clamp;
	logic signed [RSUM_W-1:0] rnd_sum;
	sat_res_t                 rnd_res;
	logic signed [DATA_W:0]   add_sum;
	sat_res_t                 add_res;
	logic                     out_free;

	assign accept   = sample.valid && sample.ready;
	assign out_free = !out_valid_q || result.ready;
	assign sample.ready = (state_q == S_IDLE);

	assign deg_eff  = (poly_degree_q > DEG_CAP) ? DEG_CAP : poly_degree_q;
	// one coefficient read port: highest term at clamp time, next lower term on adds
	assign coef_sel = (state_q == S_CLAMP) ? deg_eff : DEG_W'(cnt_q - 1'b1);
	assign coef_rd  = coef_q[coef_sel];

	// lower bound wins, also for an inverted range
	always_comb begin
		if (x_q <= range_low_q) begin
			x_clamp = range_low_q;
		end else if (x_q >= range_high_q) begin
			x_clamp = range_high_q;
		end else begin
			x_clamp = x_q;
		end
	end

	// round half up, floor shift, then clip
	assign rnd_sum = RSUM_W'(prod_q) + ROUND_HALF;
	assign rnd_res = sat_wide(rnd_sum[RSUM_W-1:FRAC_BITS]);
	assign add_sum = (DATA_W+1)'(acc_q) + (DATA_W+1)'(coef_rd);
	assign add_res = sat_wide(WIDE_W'(add_sum));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_low_q   <= RANGE_LOW_RST;
			range_high_q  <= RANGE_HIGH_RST;
			poly_degree_q <= '0;
			for (int i = 0; i < NUM_COEF; i++) begin
				coef_q[i] <= '0;
			end
			gain_q        <= GAIN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_RANGE_LOW:    range_low_q   <= cfg_data;
				REG_RANGE_HIGH:   range_high_q  <= cfg_data;
				REG_POLY_DEGREE:  poly_degree_q <= cfg_data[DEG_W-1:0];
				REG_COEF_0:       coef_q[0]     <= cfg_data;
				REG_COEF_1:       coef_q[1]     <= cfg_data;
				REG_COEF_2:       coef_q[2]     <= cfg_data;
				REG_COEF_3:       coef_q[3]     <= cfg_data;
				REG_THERMAL_GAIN: gain_q        <= cfg_data;
				default:          ;
			endcase
		end
	end

	// sequencer and control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			factor_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// in the done state the output register is refilled below instead
			if (result.ready && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						// force items go straight to the multiplier
						state_q <= (sample.command == CMD_FORCE) ? S_MUL : S_CLAMP;
					end
				end
				S_CLAMP: state_q <= S_STEP;
				S_STEP:  state_q <= S_MUL;
				S_MUL:   state_q <= S_RND;
				S_RND: begin
					if (final_q) begin
						if (cmd_q == CMD_LAMBDA) begin
							factor_q <= rnd_res.value;
						end
						state_q <= S_DONE;
					end else begin
						state_q <= S_ADD;
					end
				end
				S_ADD:   state_q <= S_STEP;
				S_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd_q   <= sample.command;
					last_q  <= sample.last_component;
					x_q     <= sample.sample_value;
					sat_q   <= 1'b0;
					final_q <= 1'b1;
					op_a_q  <= OPA_W'(sample.sample_value);
					op_b_q  <= factor_q;
				end
			end
			S_CLAMP: begin
				x_q   <= x_clamp;
				acc_q <= coef_rd;
				cnt_q <= deg_eff;
			end
			S_STEP: begin
				if (cnt_q == '0) begin
					// last pass: scale by the unsigned thermal gain
					op_a_q  <= $signed({1'b0, gain_q});
					op_b_q  <= acc_q;
					final_q <= 1'b1;
				end else begin
					op_a_q  <= OPA_W'(acc_q);
					op_b_q  <= x_q;
					final_q <= 1'b0;
				end
			end
			S_MUL: prod_q <= op_a_q * op_b_q;
			S_RND: begin
				acc_q <= rnd_res.value;
				sat_q <= sat_q | rnd_res.flag;
			end
			S_ADD: begin
				acc_q <= add_res.value;
				sat_q <= sat_q | add_res.flag;
				cnt_q <= DEG_W'(cnt_q - 1'b1);
			end
			S_DONE: begin
				if (out_free) begin
					out_kind_q  <= cmd_q;
					out_value_q <= acc_q;
					out_sat_q   <= sat_q;
					out_last_q  <= (cmd_q == CMD_FORCE) ? last_q : 1'b0;
				end
			end
			default: ;
		endcase
	end

	assign result.valid        = out_valid_q;
	assign result.kind         = out_kind_q;
	assign result.result_value = out_value_q;
	assign result.saturated    = out_sat_q;
	assign result.last_out     = out_last_q;

endmodule

>>> rtl/cpfs_checker.sv
// port-level assertions for the clamped polynomial force scaler core
// depends on cpfs_pkg; bound to clamped_poly_force_scaler_core below
module cpfs_checker (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_valid,
	input logic                   in_ready,
	input logic                   out_valid,
	input logic                   out_ready,
	input logic                   out_kind,
	input logic [cpfs_pkg::DATA_W-1:0] out_value,
	input logic                   out_last
);
	import cpfs_pkg::*;

	// one item at a time: ready drops after each accepted transaction
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready stayed high after an accepted sample");

	// a factor result never carries the last marker
	a_factor_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_kind == CMD_LAMBDA) |-> !out_last)
		else $error("factor result with last_out set");

	a_out_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result valid dropped while stalled");

	a_out_payload_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_value) && $stable(out_kind))
		else $error("result payload changed while stalled");

endmodule

bind clamped_poly_force_scaler_core cpfs_checker u_cpfs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (sample.valid),
	.in_ready  (sample.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_kind  (result.kind),
	.out_value (result.result_value),
	.out_last  (result.last_out)
);
